[rtl/control_source_failover_arbiter_defines.svh]
// ----------------------------------------------------------------------------
// control_source_failover_arbiter_defines
// Assertion macros for the control source failover arbiter.
// ----------------------------------------------------------------------------
`ifndef CONTROL_SOURCE_FAILOVER_ARBITER_DEFINES_SVH
`define CONTROL_SOURCE_FAILOVER_ARBITER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CFSFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfsfa check failed");

// next-cycle implication
`define CFSFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfsfa check failed");

`else

`define CFSFA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CFSFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/cfsfa_pkg.sv]
// ----------------------------------------------------------------------------
// cfsfa_pkg
// Types and constants shared by the control source failover arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package cfsfa_pkg;

    localparam int unsigned MS_W      = 16;
    localparam int unsigned ELAPSED_W = 10;
    localparam int unsigned NUM_CH    = 4;
    localparam int unsigned NUM_CLAIM = 3;

    localparam logic [MS_W-1:0] TIMEOUT_RESET = 16'd500;
    localparam logic [MS_W-1:0] MS_MAX        = 16'hFFFF;

    // channel bit positions
    localparam int unsigned CH_FLIGHT   = 0;
    localparam int unsigned CH_ENGINE   = 1;
    localparam int unsigned CH_AVIONICS = 2;
    localparam int unsigned CH_PANEL    = 3;

    // claim channel code that names no channel
    localparam logic [1:0] CLAIM_NONE = 2'd3;

    typedef enum logic [1:0] {
        FUNC_TICK      = 2'd0,
        FUNC_HEARTBEAT = 2'd1,
        FUNC_SIM_STATE = 2'd2,
        FUNC_CLAIM     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        SRC_FROZEN     = 2'd0,
        SRC_HARDWARE   = 2'd1,
        SRC_VIRTUAL    = 2'd2,
        SRC_INSTRUCTOR = 2'd3
    } src_t;

    typedef struct packed {
        func_t                func;
        logic [ELAPSED_W-1:0] delta_ms;
        logic [NUM_CH-1:0]    health_mask;
        logic                 frozen_state;
        logic [1:0]           claim_channel;
        logic                 panel_forced_any;
    } item_t;

    typedef struct packed {
        logic [NUM_CH-1:0]    health;
        logic [NUM_CLAIM-1:0] claims;
        logic                 frozen;
        logic                 hb_seen;
        logic [MS_W-1:0]      ms_since_hb;
        src_t                 flight_src;
        src_t                 engine_src;
        src_t                 avionics_src;
        src_t                 panel_src;
    } state_t;

    typedef struct packed {
        src_t              flight_sel;
        src_t              engine_sel;
        src_t              avionics_sel;
        src_t              panel_sel;
        logic [NUM_CH-1:0] healthy_bits;
        logic [NUM_CH-1:0] fallback_alerts;
        logic              snapshot_strobe;
        logic              is_frozen;
    } result_t;

endpackage

`default_nettype wire

[rtl/cfsfa_if.sv]
// ----------------------------------------------------------------------------
// cfsfa_if
// Valid/ready channels for arbiter input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfsfa_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [9:0] delta_ms;
    logic [3:0] health_mask;
    logic       frozen_state;
    logic [1:0] claim_channel;
    logic       panel_forced_any;

    modport source (
        output valid, func, delta_ms, health_mask, frozen_state,
               claim_channel, panel_forced_any,
        input  ready
    );
    modport sink (
        input  valid, func, delta_ms, health_mask, frozen_state,
               claim_channel, panel_forced_any,
        output ready
    );
endinterface

interface cfsfa_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] flight_sel;
    logic [1:0] engine_sel;
    logic [1:0] avionics_sel;
    logic [1:0] panel_sel;
    logic [3:0] healthy_bits;
    logic [3:0] fallback_alerts;
    logic       snapshot_strobe;
    logic       is_frozen;

    modport source (
        output valid, flight_sel, engine_sel, avionics_sel, panel_sel,
               healthy_bits, fallback_alerts, snapshot_strobe, is_frozen,
        input  ready
    );
    modport sink (
        input  valid, flight_sel, engine_sel, avionics_sel, panel_sel,
               healthy_bits, fallback_alerts, snapshot_strobe, is_frozen,
        output ready
    );
endinterface

`default_nettype wire

[rtl/control_source_failover_arbiter.sv]
// ----------------------------------------------------------------------------
// control_source_failover_arbiter
// Selects the driving source for the flight, engine, avionics and panel
// control channels, with heartbeat timeout failover and freeze handling.
// ----------------------------------------------------------------------------
//  port      | kind         | width       | role
//  in_ch     | valid/ready  | 20b payload | tick, heartbeat, sim state, claim
//  out_ch    | valid/ready  | 18b payload | sources, health, alerts, freeze
//  cfg_wr_*  | write strobe | 16b         | heartbeat timeout in ms
//
//  One beat per cycle sustained while out_ch is ready; each beat is held in
//  the input register and then resolved into the result register.
//  A stalled result holds; input keeps flowing until both registers fill.
//  Reset: all channels unhealthy, no claims, not frozen, sources virtual,
//  timeout 500 ms.
// ----------------------------------------------------------------------------
`default_nettype none
`include "control_source_failover_arbiter_defines.svh"

module control_source_failover_arbiter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [cfsfa_pkg::MS_W-1:0] cfg_wr_data,
    cfsfa_in_if.sink                   in_ch,
    cfsfa_out_if.source                out_ch
);
    import cfsfa_pkg::*;

    logic            in_valid_reg;
    item_t           item_reg;
    logic            out_valid_reg;
    result_t         res_reg;
    state_t          state_reg;
    state_t          state_next;
    result_t         res_next;
    logic [MS_W-1:0] timeout_reg;
    logic            advance;
    state_t          state_rst;

    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    always_comb
    begin
        state_rst              = '0;
        state_rst.flight_src   = SRC_VIRTUAL;
        state_rst.engine_src   = SRC_VIRTUAL;
        state_rst.avionics_src = SRC_VIRTUAL;
        state_rst.panel_src    = SRC_VIRTUAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RESET;
        else if (cfg_wr_en)
            timeout_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            item_reg.func             <= func_t'(in_ch.func);
            item_reg.delta_ms         <= in_ch.delta_ms;
            item_reg.health_mask      <= in_ch.health_mask;
            item_reg.frozen_state     <= in_ch.frozen_state;
            item_reg.claim_channel    <= in_ch.claim_channel;
            item_reg.panel_forced_any <= in_ch.panel_forced_any;
        end
    end

    cfsfa_step u_step (
        .cur        (state_reg),
        .item       (item_reg),
        .timeout_ms (timeout_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= state_rst;
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.flight_sel      = res_reg.flight_sel;
    assign out_ch.engine_sel      = res_reg.engine_sel;
    assign out_ch.avionics_sel    = res_reg.avionics_sel;
    assign out_ch.panel_sel       = res_reg.panel_sel;
    assign out_ch.healthy_bits    = res_reg.healthy_bits;
    assign out_ch.fallback_alerts = res_reg.fallback_alerts;
    assign out_ch.snapshot_strobe = res_reg.snapshot_strobe;
    assign out_ch.is_frozen       = res_reg.is_frozen;

    // a strobe only comes with the frozen flag set
    `CFSFA_ASSERT_IMP(a_strobe_frozen, clk, rst_n, out_valid_reg && res_reg.snapshot_strobe, res_reg.is_frozen)
    // an alerted channel is unhealthy after that beat
    `CFSFA_ASSERT_IMP(a_alert_unhealthy, clk, rst_n, out_valid_reg, (res_reg.fallback_alerts & res_reg.healthy_bits) == '0)
    // instructor claims never drop
    `CFSFA_ASSERT_NEXT(a_claims_sticky, clk, rst_n, 1'b1, (state_reg.claims & $past(state_reg.claims)) == $past(state_reg.claims))

endmodule

`default_nettype wire

[rtl/cfsfa_step.sv]
// ----------------------------------------------------------------------------
// cfsfa_step
// Next-state and result logic for one item: time count, health, claims,
// freeze and per-channel source resolution.
// ----------------------------------------------------------------------------
`default_nettype none

module cfsfa_step (
    input  cfsfa_pkg::state_t          cur,
    input  cfsfa_pkg::item_t           item,
    input  logic [cfsfa_pkg::MS_W-1:0] timeout_ms,
    output cfsfa_pkg::state_t          nxt,
    output cfsfa_pkg::result_t         res
);
    import cfsfa_pkg::*;

    function automatic src_t pick_source(input logic claimed, input logic healthy);
        if (claimed)
            return SRC_INSTRUCTOR;
        else if (healthy)
            return SRC_HARDWARE;
        else
            return SRC_VIRTUAL;
    endfunction

    logic [MS_W:0]     ms_sum;
    logic [MS_W-1:0]   ms_sat;
    logic [NUM_CH-1:0] alerts;
    logic              strobe;

    assign ms_sum = {1'b0, cur.ms_since_hb} + {{(MS_W + 1 - ELAPSED_W){1'b0}}, item.delta_ms};
    assign ms_sat = ms_sum[MS_W] ? MS_MAX : ms_sum[MS_W-1:0];

    always_comb
    begin
        nxt             = cur;
        nxt.ms_since_hb = ms_sat;
        alerts          = '0;
        strobe          = 1'b0;

        case (item.func)
            FUNC_HEARTBEAT:
            begin
                alerts          = cur.health & ~item.health_mask;
                nxt.health      = item.health_mask;
                nxt.ms_since_hb = '0;
                nxt.hb_seen     = 1'b1;
            end
            FUNC_SIM_STATE:
            begin
                strobe     = item.frozen_state & ~cur.frozen;
                nxt.frozen = item.frozen_state;
            end
            FUNC_CLAIM:
            begin
                if (item.claim_channel != CLAIM_NONE)
                    nxt.claims = cur.claims | (NUM_CLAIM'(1) << item.claim_channel);
            end
            FUNC_TICK:
            begin
                if (cur.hb_seen && (ms_sat > timeout_ms))
                begin
                    alerts     = cur.health;
                    nxt.health = '0;
                end
                if (cur.frozen)
                begin
                    nxt.flight_src   = SRC_FROZEN;
                    nxt.engine_src   = SRC_FROZEN;
                    nxt.avionics_src = SRC_FROZEN;
                    nxt.panel_src    = SRC_FROZEN;
                end
                else
                begin
                    nxt.flight_src   = pick_source(cur.claims[CH_FLIGHT],
                                                   nxt.health[CH_FLIGHT]);
                    nxt.engine_src   = pick_source(cur.claims[CH_ENGINE],
                                                   nxt.health[CH_ENGINE]);
                    nxt.avionics_src = pick_source(cur.claims[CH_AVIONICS],
                                                   nxt.health[CH_AVIONICS]);
                    nxt.panel_src    = pick_source(item.panel_forced_any,
                                                   nxt.health[CH_PANEL]);
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    always_comb
    begin
        res.flight_sel      = nxt.flight_src;
        res.engine_sel      = nxt.engine_src;
        res.avionics_sel    = nxt.avionics_src;
        res.panel_sel       = nxt.panel_src;
        res.healthy_bits    = nxt.health;
        res.fallback_alerts = alerts;
        res.snapshot_strobe = strobe;
        res.is_frozen       = nxt.frozen;
    end

endmodule

`default_nettype wire
